/* sv/sample_window_min_max_mean_defines.svh */
// Assertion macros shared by the sample window block.
// Each macro expects signals named clk and arst_n in the including scope.
`ifndef SAMPLE_WINDOW_MIN_MAX_MEAN_DEFINES_SVH
`define SAMPLE_WINDOW_MIN_MAX_MEAN_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SMM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked outside reset.
`define SMM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

/* sv/smm_pkg.sv */
// Shared types for the sample window min/max/mean block.
// No dependencies; used by the controller, the datapath and the interfaces.
package smm_pkg;

	typedef logic signed [7:0] sample_t;
	typedef logic [7:0]        count8_t;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic accept;    // latch the new sample and read the slot it replaces
		logic update;    // update ring, sum, count and extremes; start the divider
		logic div_step;  // one quotient bit
		logic load_out;  // move the finished result into the output register
	} cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic div_last;  // the current divider step yields the last quotient bit
	} stat_t;

endpackage

/* sv/smm_in_if.sv */
// Input channel carrying one temperature sample per item.
// Depends on smm_pkg for the sample type.
interface smm_in_if;
	import smm_pkg::*;

	logic    valid;
	logic    ready;
	sample_t sample;

	modport source (output valid, output sample, input ready);
	modport sink (input valid, input sample, output ready);
endinterface

/* sv/smm_out_if.sv */
// Output channel carrying one statistics result per item.
// Depends on smm_pkg for the field types.
interface smm_out_if;
	import smm_pkg::*;

	logic    valid;
	logic    ready;
	sample_t current;
	sample_t minimum;
	sample_t maximum;
	sample_t mean;
	count8_t filled;

	modport source (output valid, output current, output minimum, output maximum,
		output mean, output filled, input ready);
	modport sink (input valid, input current, input minimum, input maximum,
		input mean, input filled, output ready);
endinterface

/* sv/smm_ram.sv */
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module smm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 128
) (
	input  logic                                      clk,
	input  logic                                      we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                          wdata,
	input  logic                                      re,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                          rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end
endmodule

/* sv/smm_ctrl.sv */
// Controller state machine of the sample window block.
// Depends on smm_pkg and the assertion macros header.
`include "sample_window_min_max_mean_defines.svh"

module smm_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	output smm_pkg::cmd_t cmd,
	input  smm_pkg::stat_t stat
);
	import smm_pkg::*;

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_READ = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_OUT  = 2'd3;

	logic [1:0] state_q, state_d;
	logic       out_valid_q;

	assign in_ready  = (state_q == S_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d      = state_q;
		cmd          = '0;
		unique case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = S_READ;
				end
			end
			S_READ: begin
				cmd.update = 1'b1;
				state_d    = S_DIV;
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (stat.div_last) begin
					state_d = S_OUT;
				end
			end
			S_OUT: begin
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	`SMM_ASSERT_NXT(a_accept_reads, in_valid && in_ready, state_q == S_READ, "accept did not start a read")
	`SMM_ASSERT_IMP(a_load_free, cmd.load_out, !out_valid_q || out_ready, "result overwritten")
	`SMM_ASSERT_NXT(a_update_divides, cmd.update, state_q == S_DIV, "divider not started")
endmodule

/* sv/smm_dp.sv */
// Datapath of the sample window block: ring memory, running sum, count,
// extremes, bit-serial divider and output register. Depends on smm_pkg, smm_ram.
module smm_dp #(
	parameter int WINDOW = 128
) (
	input  logic             clk,
	input  logic             arst_n,
	input  smm_pkg::cmd_t    cmd,
	output smm_pkg::stat_t   stat,
	input  smm_pkg::sample_t sample,
	output smm_pkg::sample_t current,
	output smm_pkg::sample_t minimum,
	output smm_pkg::sample_t maximum,
	output smm_pkg::sample_t mean,
	output smm_pkg::count8_t filled
);
	import smm_pkg::*;

	localparam int AW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
	localparam int CW  = $clog2(WINDOW + 1);
	localparam int SW  = 8 + CW;
	localparam int DCW = $clog2(SW);

	logic [AW-1:0]        pos_q;
	logic [CW-1:0]        cnt_q;
	logic signed [SW-1:0] sum_q;
	sample_t              lo_q, hi_q, smp_q;
	sample_t              old_smp;

	logic                 full;
	logic signed [SW-1:0] sum_sub, sum_new, old_ext, smp_ext;
	logic [CW-1:0]        cnt_new;

	// Divider state. The remainder always stays below the count.
	logic [SW-1:0]  quo_q;
	logic [CW-1:0]  rem_q;
	logic           neg_q;
	logic [DCW-1:0] step_q;
	logic [CW:0]    rem_sh, divisor;
	logic           fits;
	logic [7:0]     quo8;

	smm_ram #(.WIDTH(8), .DEPTH(WINDOW)) u_ring (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (pos_q),
		.wdata (smp_q),
		.re    (cmd.accept),
		.raddr (pos_q),
		.rdata (old_smp)
	);

	assign full    = (cnt_q == CW'(WINDOW));
	assign old_ext = {{(SW-8){old_smp[7]}}, old_smp};
	assign smp_ext = {{(SW-8){smp_q[7]}}, smp_q};
	assign sum_sub = full ? (sum_q - old_ext) : sum_q;
	assign sum_new = sum_sub + smp_ext;
	assign cnt_new = full ? cnt_q : (cnt_q + CW'(1));

	assign divisor  = {1'b0, cnt_q};
	assign rem_sh   = {rem_q, quo_q[SW-1]};
	assign fits     = (rem_sh >= divisor);
	assign stat.div_last = (step_q == DCW'(SW - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q  <= '0;
			cnt_q  <= '0;
			sum_q  <= '0;
			lo_q   <= 8'sd127;
			hi_q   <= -8'sd128;
			step_q <= '0;
		end else begin
			if (cmd.update) begin
				pos_q  <= (pos_q == AW'(WINDOW - 1)) ? '0 : (pos_q + AW'(1));
				cnt_q  <= cnt_new;
				sum_q  <= sum_new;
				step_q <= '0;
				if (smp_q < lo_q) begin
					lo_q <= smp_q;
				end
				if (smp_q > hi_q) begin
					hi_q <= smp_q;
				end
			end else if (cmd.div_step) begin
				step_q <= step_q + DCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			smp_q <= sample;
		end
		if (cmd.update) begin
			// The magnitude of the most negative sum still fits as unsigned.
			quo_q <= sum_new[SW-1] ? SW'(-sum_new) : SW'(sum_new);
			neg_q <= sum_new[SW-1];
			rem_q <= '0;
		end else if (cmd.div_step) begin
			rem_q <= fits ? CW'(rem_sh - divisor) : rem_sh[CW-1:0];
			quo_q <= {quo_q[SW-2:0], fits};
		end
	end

	assign quo8 = quo_q[7:0];

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			current <= smp_q;
			minimum <= lo_q;
			maximum <= hi_q;
			mean    <= neg_q ? sample_t'(-quo8) : sample_t'(quo8);
			filled  <= count8_t'(cnt_q);
		end
	end
endmodule

/* sv/sample_window_min_max_mean.sv */
// Top level of the sample window min/max/mean block.
// Depends on smm_pkg, smm_in_if, smm_out_if, smm_ctrl, smm_dp and smm_ram.
//
//  channel   | dir | interface  | payload
//  ----------+-----+------------+-------------------------------------------
//  samples   | in  | smm_in_if  | sample (signed 8)
//  results   | out | smm_out_if | current, minimum, maximum, mean (signed 8),
//            |     |            | filled (unsigned 8)
//
// Each item goes through these steps: accept and read the slot it replaces,
// update the ring, sum, count and extremes, run the bit-serial divider at one
// quotient bit per cycle (8 + clog2(WINDOW+1) bits), then load the output
// register. The divider loop sets the rate.
// Reset is asynchronous and active low; it empties the window, sets the
// extremes so the first sample becomes both, and needs no clearing pass.
// A result waiting on results.ready holds the output register; the block
// finishes the next item and waits only when it would overwrite that result.
module sample_window_min_max_mean #(
	parameter int WINDOW = 128
) (
	input logic        clk,
	input logic        arst_n,
	smm_in_if.sink     samples,
	smm_out_if.source  results
);
	import smm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// The controller sequences each item; the datapath holds all values.
	smm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (samples.valid),
		.in_ready  (samples.ready),
		.out_valid (results.valid),
		.out_ready (results.ready),
		.cmd       (cmd),
		.stat      (stat)
	);

	smm_dp #(.WINDOW(WINDOW)) u_dp (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.stat    (stat),
		.sample  (samples.sample),
		.current (results.current),
		.minimum (results.minimum),
		.maximum (results.maximum),
		.mean    (results.mean),
		.filled  (results.filled)
	);
endmodule
